// ===== rtl/core/stic_pkg.sv =====
// Shared types and constants for the cooler integral controller.
package stic_pkg;

    localparam int unsigned TEMP_W   = 16;
    localparam int unsigned TARGET_W = 11;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [TEMP_W-1:0]   ZERO_DEG_TENTHS = 16'd1280;
    localparam logic [TARGET_W-1:0] TARGET_RESET    = 11'd1730;
    localparam logic [TEMP_W-1:0]   TEMP_ALL_ONES   = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COOLER_ENABLE = 1'b0,
        CFG_TARGET_TEMP   = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic              usable;
    } t_conv;

    // floor(sum of 62.5/125/250/500 weights / 100) for one fraction nibble
    function automatic logic [3:0] frac_tenths(input logic [3:0] nib);
        logic [3:0] res;
        case (nib)
            4'd0:    res = 4'd0;
            4'd1:    res = 4'd0;
            4'd2:    res = 4'd1;
            4'd3:    res = 4'd1;
            4'd4:    res = 4'd2;
            4'd5:    res = 4'd3;
            4'd6:    res = 4'd3;
            4'd7:    res = 4'd4;
            4'd8:    res = 4'd5;
            4'd9:    res = 4'd5;
            4'd10:   res = 4'd6;
            4'd11:   res = 4'd6;
            4'd12:   res = 4'd7;
            4'd13:   res = 4'd8;
            4'd14:   res = 4'd8;
            4'd15:   res = 4'd9;
            default: res = 4'd0;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/core/stic_convert.sv =====
// Thermometer word to tenths of a degree plus offset, with usability check.
module stic_convert
    import stic_pkg::*;
(
    input  logic [TEMP_W-1:0] i_raw,
    input  logic              i_discarded,
    output t_conv             o_conv
);

    logic              neg;
    logic [TEMP_W-1:0] mag;
    logic [TEMP_W-1:0] tenths;
    logic [TEMP_W-1:0] temp;

    always_comb begin
        neg    = i_raw[TEMP_W-1];
        mag    = neg ? (~i_raw + 16'd1) : i_raw;
        tenths = TEMP_W'(mag[TEMP_W-1:4] * 16'd10) + TEMP_W'(frac_tenths(mag[3:0]));
        temp   = neg ? (ZERO_DEG_TENTHS - tenths) : (tenths + ZERO_DEG_TENTHS);
        o_conv.temp   = temp;
        o_conv.usable = !i_discarded && (temp != '0) && (temp != TEMP_ALL_ONES);
    end

endmodule

// ===== rtl/core/sensor_temp_integral_cooler_control.sv =====
// Cooler control top level: reading conversion, integral term and on-time output.
// Takes one beat per cycle while the output is not stalled: the reading is registered,
// then conversion, the integral add and clamp and the divide by 25 (a constant
// multiply) run combinationally into the result register. The integral and kept
// temperature update with the result register, so consecutive beats follow back to back.
module sensor_temp_integral_cooler_control
    import stic_pkg::*;
#(
    parameter int unsigned CYCLE_MS = 1020
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TARGET_W-1:0]  i_cfg_data,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [15:0]          i_s_tdata,  // raw_reading[15:0]
    input  logic                 i_s_tuser,  // reading_discarded
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [39:0]          o_m_tdata   // sensor_temp[15:0], on_time_ms[25:16],
                                             // cooler_power[33:26], zero[39:34]
);

    localparam int unsigned LIMIT_VAL = 25 * CYCLE_MS;
    localparam int unsigned IW        = $clog2(LIMIT_VAL + 1);
    localparam int unsigned SW        = ((IW > TEMP_W) ? IW : TEMP_W) + 2;
    localparam int unsigned DIV_SHIFT = 22;
    localparam int unsigned DIV_MUL   = ((2 ** DIV_SHIFT) + 24) / 25;
    localparam int unsigned PW        = IW + 18;
    localparam logic [IW-1:0] LIMIT   = IW'(LIMIT_VAL);

    logic                r_enable;
    logic [TARGET_W-1:0] r_target;
    logic                r_in_valid;
    logic [15:0]         r_raw;
    logic                r_disc;
    logic [IW-1:0]       r_integral;
    logic [TEMP_W-1:0]   r_kept;
    logic                r_out_valid;
    logic [TEMP_W-1:0]   r_out_temp;
    logic [9:0]          r_on_time;
    logic [7:0]          r_power;

    logic                advance;
    logic                process;
    t_conv               conv;
    logic [TEMP_W-1:0]   n_kept;
    logic signed [SW-1:0] sum;
    logic [IW-1:0]       n_integral;
    logic [PW-1:0]       prod;
    logic [PW-1:0]       quot;

    stic_convert u_convert (
        .i_raw       (r_raw),
        .i_discarded (r_disc),
        .o_conv      (conv)
    );

    assign advance    = !r_out_valid || i_m_tready;
    assign process    = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;

    always_comb begin
        n_kept = conv.usable ? conv.temp : r_kept;
        sum    = $signed(SW'(r_integral)) + $signed(SW'(n_kept)) - $signed(SW'(r_target));
        if (!r_enable) begin
            n_integral = '0;
        end else if (sum > $signed(SW'(LIMIT))) begin
            n_integral = LIMIT;
        end else if (sum < 0) begin
            n_integral = '0;
        end else begin
            n_integral = IW'(sum);
        end
        prod = PW'(n_integral) * PW'(DIV_MUL);
        quot = prod >> DIV_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_target <= TARGET_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_COOLER_ENABLE: r_enable <= i_cfg_data[0];
                CFG_TARGET_TEMP:   r_target <= i_cfg_data;
                default:           r_enable <= r_enable;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_integral  <= '0;
            r_kept      <= ZERO_DEG_TENTHS;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (process) begin
                r_integral <= n_integral;
                r_kept     <= n_kept;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_raw  <= i_s_tdata;
            r_disc <= i_s_tuser;
        end
        if (process) begin
            r_out_temp <= n_kept;
            r_on_time  <= quot[9:0];
            r_power    <= quot[9:2];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_power, r_on_time, r_out_temp};

    a_integral_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_integral <= LIMIT)
        else $error("integral above limit");

    a_disabled_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && !r_enable) |=> (r_integral == '0))
        else $error("integral not cleared while disabled");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process |=> r_out_valid)
        else $error("processed beat lost");

    a_power_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_power == r_on_time[9:2]))
        else $error("power does not match on-time");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_raw)))
        else $error("input beat dropped under stall");

endmodule
